// ===== hdl/spf_pkg.sv =====
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types and constants of the scan line polygon span fill block.
// ----------------------------------------------------------------------------
package spf_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int FRAC_BITS    = 16;
  localparam int SCREEN_ROWS  = 480;
  localparam int X_W          = 10;
  localparam int Y_W          = 9;
  localparam int VADDR_W      = $clog2(MAX_VERTICES);
  localparam int VCNT_W       = $clog2(MAX_VERTICES + 1);
  localparam int DIV_W        = X_W + FRAC_BITS;
  localparam int DCNT_W       = $clog2(DIV_W);
  localparam int SLOPE_W      = DIV_W + 1;
  localparam int PROD_W       = SLOPE_W + Y_W + 1;
  localparam int Q_W          = PROD_W + 1;
  localparam int VTX_W        = X_W + Y_W;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic           req_type;
    logic [X_W-1:0] vertex_x;
    logic [Y_W-1:0] vertex_y;
    logic           vertex_last;
    logic [Y_W-1:0] scan_y;
  } spf_req_t;

  typedef struct packed {
    logic [X_W-1:0] span_start;
    logic [X_W-1:0] span_end;
    logic           span_valid;
    logic [Y_W-1:0] scan_line;
    logic           span_last;
  } spf_res_t;

  typedef struct packed {
    logic               vtx_we;
    logic [VADDR_W-1:0] vtx_waddr;
    logic               rd_en;
    logic [VADDR_W-1:0] rd_addr;
    logic               latch_row;
    logic               cap_first;
    logic               cur_from_ram;
    logic               cur_from_first;
    logic               prev_from_cur;
    logic               div_load;
    logic               div_step;
    logic               mul_en;
    logic               ins_en;
    logic               list_clr;
    logic               emit_pop;
  } spf_cmd_t;

  typedef struct packed {
    logic straddle;
    logic last_res;
  } spf_sts_t;

endpackage

// ===== hdl/scanline_polygon_span_fill.sv =====
// ----------------------------------------------------------------------------
// scanline_polygon_span_fill
// Stores polygon vertices and returns the fill spans of one scan line.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. A vertex load
//   (req_type 0) gives no result and leaves busy low, so loads can follow
//   back to back. A vertex with vertex_last set closes the polygon; the
//   next load starts a new one. Vertices past sixteen are lost.
//   A query (req_type 1) raises busy until its last result has gone out.
//   Results appear one per cycle on res_o, marked by res_strobe_o, span_last
//   set on the final one; the receiver cannot stall, each beat lasts exactly
//   one cycle. An empty line gives one beat with span_valid low.
//   A query walks the edges between the stored vertices; each crossing
//   edge costs a 26-step serial divide plus a multiply and a sorted insert
//   before the first beat.
//   Rows at or past the screen height skip the edge walk and give one empty beat.
//   After reset the vertex list is empty and the next load starts a polygon.
// ----------------------------------------------------------------------------
module scanline_polygon_span_fill
  import spf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  spf_req_t req_i,
  output logic     busy,
  output logic     res_strobe_o,
  output spf_res_t res_o
);

  spf_cmd_t cmd;
  spf_sts_t sts;

  spf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .req_i    (req_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy     (busy),
    .strobe_o (res_strobe_o)
  );

  spf_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .res_o  (res_o)
  );

  a_strobe_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> busy) else $error("result beat outside a query");

  a_last_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && res_o.span_last |=> !res_strobe_o)
    else $error("beat after last span");

  a_empty_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !res_o.span_valid |-> res_o.span_last)
    else $error("empty result not last");

  a_ordered : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && res_o.span_valid |-> res_o.span_start <= res_o.span_end)
    else $error("span out of order");

endmodule

// ===== hdl/spf_ram.sv =====
// ----------------------------------------------------------------------------
// spf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module spf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hdl/spf_datapath.sv =====
// ----------------------------------------------------------------------------
// spf_datapath
// Vertex store, edge registers, serial divider, slope multiplier and the
// sorted crossing list.
// ----------------------------------------------------------------------------
module spf_datapath
  import spf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  spf_req_t req_i,
  input  spf_cmd_t cmd_i,
  output spf_sts_t sts_o,
  output spf_res_t res_o
);

  logic [VTX_W-1:0]        rdata;
  logic [VTX_W-1:0]        first_q, prev_q, cur_q;
  logic [Y_W-1:0]          row_q;
  logic [Y_W-1:0]          rem_q;
  logic [Y_W-1:0]          dvs_q;
  logic [DIV_W-1:0]        quo_q;
  logic                    neg_q;
  logic signed [Y_W:0]     dyr_q;
  logic [X_W-1:0]          x0_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [X_W-1:0]          list_q [MAX_VERTICES];
  logic [VCNT_W-1:0]       cnt_q;

  logic [X_W-1:0] px, cx;
  logic [Y_W-1:0] py, cy;
  logic signed [X_W:0] dx;
  logic signed [Y_W:0] dy;
  logic [X_W-1:0] adx;
  logic [Y_W-1:0] ady;
  logic [Y_W:0]   trial;
  logic           fits;
  logic signed [SLOPE_W-1:0] slope;
  logic signed [Q_W-1:0]     qv;
  logic [X_W-1:0]            xi;
  logic [MAX_VERTICES-1:0]   le;

  spf_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_vtx_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.vtx_we),
    .waddr_i (cmd_i.vtx_waddr),
    .wdata_i ({req_i.vertex_x, req_i.vertex_y}),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.rd_addr),
    .rdata_o (rdata)
  );

  assign px = prev_q[VTX_W-1:Y_W];
  assign py = prev_q[Y_W-1:0];
  assign cx = cur_q[VTX_W-1:Y_W];
  assign cy = cur_q[Y_W-1:0];
  assign dx = $signed({1'b0, cx}) - $signed({1'b0, px});
  assign dy = $signed({1'b0, cy}) - $signed({1'b0, py});
  assign adx = dx[X_W] ? X_W'(-dx) : dx[X_W-1:0];
  assign ady = dy[Y_W] ? Y_W'(-dy) : dy[Y_W-1:0];

  // half-open straddle test, horizontal edges never pass
  assign sts_o.straddle = ((py <= row_q) && (cy > row_q)) || ((py > row_q) && (cy <= row_q));
  assign sts_o.last_res = (cnt_q <= VCNT_W'(2));

  // restoring division step
  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  assign slope = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign qv = $signed({{(Q_W-X_W-FRAC_BITS){1'b0}}, x0_q, {FRAC_BITS{1'b0}}})
            + Q_W'(prod_q);

  always_comb begin
    if (qv[Q_W-1]) begin
      xi = '0;
    end else if (qv[Q_W-2:X_W+FRAC_BITS] != '0) begin
      xi = '1;
    end else begin
      xi = qv[FRAC_BITS +: X_W];
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_VERTICES; j++) begin
      le[j] = (VCNT_W'(j) < cnt_q) && (list_q[j] <= xi);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.list_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.ins_en) begin
      cnt_q <= cnt_q + VCNT_W'(1);
    end else if (cmd_i.emit_pop) begin
      cnt_q <= (cnt_q >= VCNT_W'(2)) ? cnt_q - VCNT_W'(2) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_row) begin
      row_q <= req_i.scan_y;
    end
    if (cmd_i.cap_first) begin
      first_q <= rdata;
      prev_q  <= rdata;
    end else if (cmd_i.prev_from_cur) begin
      prev_q <= cur_q;
    end
    if (cmd_i.cur_from_ram) begin
      cur_q <= rdata;
    end else if (cmd_i.cur_from_first) begin
      cur_q <= first_q;
    end
    if (cmd_i.div_load) begin
      rem_q <= '0;
      dvs_q <= ady;
      quo_q <= {adx, {FRAC_BITS{1'b0}}};
      neg_q <= dx[X_W] ^ dy[Y_W];
      dyr_q <= $signed({1'b0, row_q}) - $signed({1'b0, py});
      x0_q  <= px;
    end else if (cmd_i.div_step) begin
      rem_q <= fits ? Y_W'(trial - {1'b0, dvs_q}) : trial[Y_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
    if (cmd_i.mul_en) begin
      prod_q <= PROD_W'(slope * dyr_q);
    end
    if (cmd_i.ins_en) begin
      for (int j = 0; j < MAX_VERTICES; j++) begin
        if (le[j]) begin
          list_q[j] <= list_q[j];
        end else if (j == 0) begin
          list_q[j] <= xi;
        end else if (le[j-1]) begin
          list_q[j] <= xi;
        end else begin
          list_q[j] <= list_q[j-1];
        end
      end
    end else if (cmd_i.emit_pop) begin
      for (int j = 0; j < MAX_VERTICES - 2; j++) begin
        list_q[j] <= list_q[j+2];
      end
    end
  end

  always_comb begin
    res_o.scan_line  = row_q;
    res_o.span_last  = sts_o.last_res;
    res_o.span_valid = (cnt_q != '0);
    if (cnt_q == '0) begin
      res_o.span_start = '0;
      res_o.span_end   = '0;
    end else begin
      res_o.span_start = list_q[0];
      res_o.span_end   = (cnt_q >= VCNT_W'(2)) ? list_q[1] : list_q[0];
    end
  end

endmodule

// ===== hdl/spf_ctrl.sv =====
// ----------------------------------------------------------------------------
// spf_ctrl
// Controller: vertex bookkeeping, edge walk, divide/multiply sequencing and
// span output.
// ----------------------------------------------------------------------------
module spf_ctrl
  import spf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  spf_req_t req_i,
  input  spf_sts_t sts_i,
  output spf_cmd_t cmd_o,
  output logic     busy,
  output logic     strobe_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD_FIRST, ST_RD_NEXT, ST_EDGE, ST_DIV, ST_MUL, ST_ADD, ST_EMIT
  } state_e;

  state_e              state_q, state_d;
  logic [VCNT_W-1:0]   vcnt_q, vcnt_d;
  logic                closed_q, closed_d;
  logic [VCNT_W-1:0]   idx_q, idx_d;
  logic                closing_q, closing_d;
  logic [DCNT_W-1:0]   dcnt_q, dcnt_d;
  logic [VCNT_W-1:0]   nidx;
  logic [VCNT_W-1:0]   base;

  assign busy     = (state_q != ST_IDLE);
  assign strobe_o = (state_q == ST_EMIT);
  assign nidx     = idx_q + VCNT_W'(1);
  assign base     = closed_q ? '0 : vcnt_q;

  always_comb begin
    cmd_o     = '0;
    state_d   = state_q;
    vcnt_d    = vcnt_q;
    closed_d  = closed_q;
    idx_d     = idx_q;
    closing_d = closing_q;
    dcnt_d    = dcnt_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (req_i.req_type == REQ_LOAD) begin
            closed_d = req_i.vertex_last;
            vcnt_d   = base;
            if (base < VCNT_W'(MAX_VERTICES)) begin
              cmd_o.vtx_we    = 1'b1;
              cmd_o.vtx_waddr = base[VADDR_W-1:0];
              vcnt_d          = base + VCNT_W'(1);
            end
          end else begin
            cmd_o.latch_row = 1'b1;
            cmd_o.list_clr  = 1'b1;
            closing_d       = 1'b0;
            if ((32'(req_i.scan_y) >= 32'(SCREEN_ROWS)) || (vcnt_q == '0)) begin
              state_d = ST_EMIT;
            end else begin
              cmd_o.rd_en = 1'b1;
              state_d     = ST_RD_FIRST;
            end
          end
        end
      end
      ST_RD_FIRST: begin
        cmd_o.cap_first = 1'b1;
        idx_d           = VCNT_W'(1);
        if (vcnt_q == VCNT_W'(1)) begin
          cmd_o.cur_from_ram = 1'b1;
          closing_d          = 1'b1;
          state_d            = ST_EDGE;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = VADDR_W'(1);
          state_d       = ST_RD_NEXT;
        end
      end
      ST_RD_NEXT: begin
        cmd_o.cur_from_ram = 1'b1;
        state_d            = ST_EDGE;
      end
      ST_EDGE: begin
        if (sts_i.straddle) begin
          cmd_o.div_load = 1'b1;
          dcnt_d         = '0;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        dcnt_d         = dcnt_q + DCNT_W'(1);
        if (dcnt_q == DCNT_W'(DIV_W - 1)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.ins_en = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.emit_pop = 1'b1;
        if (sts_i.last_res) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // step to the next edge once this one is finished
    if ((state_q == ST_ADD) || ((state_q == ST_EDGE) && !sts_i.straddle)) begin
      cmd_o.prev_from_cur = 1'b1;
      if (closing_q) begin
        state_d = ST_EMIT;
      end else if (nidx == vcnt_q) begin
        cmd_o.cur_from_first = 1'b1;
        closing_d            = 1'b1;
        state_d              = ST_EDGE;
      end else begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = nidx[VADDR_W-1:0];
        idx_d         = nidx;
        state_d       = ST_RD_NEXT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      vcnt_q    <= '0;
      closed_q  <= 1'b1;
      idx_q     <= '0;
      closing_q <= 1'b0;
      dcnt_q    <= '0;
    end else begin
      state_q   <= state_d;
      vcnt_q    <= vcnt_d;
      closed_q  <= closed_d;
      idx_q     <= idx_d;
      closing_q <= closing_d;
      dcnt_q    <= dcnt_d;
    end
  end

endmodule

// ===== bench/scanline_polygon_span_fill_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scanline_polygon_span_fill_tb
// Loads random and hand-picked polygons, queries scan lines and compares
// every span beat against an in-bench span calculator.
// ----------------------------------------------------------------------------
module scanline_polygon_span_fill_tb;
  import spf_pkg::*;

  localparam int SPAN_CAP   = 8;
  localparam int CYCLE_CAP  = 1000000;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  spf_req_t req_i;
  logic     busy;
  logic     res_strobe_o;
  spf_res_t res_o;

  scanline_polygon_span_fill u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .req_i        (req_i),
    .busy         (busy),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

  // calculator state
  logic [X_W-1:0] poly_x [MAX_VERTICES];
  logic [Y_W-1:0] poly_y [MAX_VERTICES];
  int             poly_n;
  bit             poly_closed;

  spf_res_t span_q[$];
  int       mismatches;
  bit       timed_out;
  int       cycles;
  bit       quiet_phase;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP && !timed_out) begin
      timed_out = 1'b1;
      $display("** scanline_polygon_span_fill: FAILED **");
      $finish;
    end
  end

  // work out the spans of one query and append them to span_q
  task automatic predict_spans(input logic [Y_W-1:0] row);
    longint xs[$];
    longint x0, y0, x1, y1, slope, q, t;
    int     nx, pairs, a, b, m;
    spf_res_t r;
    if (row < SCREEN_ROWS) begin
      for (int i = 0; i < poly_n; i++) begin
        nx = (i + 1 < poly_n) ? i + 1 : 0;
        x0 = poly_x[i]; y0 = poly_y[i]; x1 = poly_x[nx]; y1 = poly_y[nx];
        if ((y0 <= row && y1 > row) || (y0 > row && y1 <= row)) begin
          slope = ((x1 - x0) * (64'sd1 <<< FRAC_BITS)) / (y1 - y0);
          q = x0 * (64'sd1 <<< FRAC_BITS) + slope * (longint'(row) - y0);
          if (q < 0) q = 0;
          if (q > 1023 * (64'sd1 <<< FRAC_BITS)) q = 1023 * (64'sd1 <<< FRAC_BITS);
          xs.push_back(q);
        end
      end
    end
    for (int i = 0; i < xs.size(); i++) begin
      m = i;
      for (int j = i + 1; j < xs.size(); j++) if (xs[j] < xs[m]) m = j;
      t = xs[i]; xs[i] = xs[m]; xs[m] = t;
    end
    if (xs.size() == 0) begin
      r = '0;
      r.scan_line = row;
      r.span_last = 1'b1;
      span_q.push_back(r);
    end else begin
      pairs = (xs.size() + 1) / 2;
      if (pairs > SPAN_CAP) pairs = SPAN_CAP;
      for (int k = 0; k < pairs; k++) begin
        a = 2 * k;
        b = (a + 1 < xs.size()) ? a + 1 : a;
        r.span_start = X_W'(xs[a] >>> FRAC_BITS);
        r.span_end   = X_W'(xs[b] >>> FRAC_BITS);
        r.span_valid = 1'b1;
        r.scan_line  = row;
        r.span_last  = (k + 1 == pairs);
        span_q.push_back(r);
      end
    end
  endtask

  task automatic store_vertex(input spf_req_t v);
    if (poly_closed) begin
      poly_n = 0;
      poly_closed = 1'b0;
    end
    if (poly_n < MAX_VERTICES) begin
      poly_x[poly_n] = v.vertex_x;
      poly_y[poly_n] = v.vertex_y;
      poly_n++;
    end
    if (v.vertex_last) poly_closed = 1'b1;
  endtask

  function automatic spf_req_t make_vertex(int x, int y, bit last);
    spf_req_t v;
    v = '0;
    v.req_type = REQ_LOAD;
    v.vertex_x = X_W'(x);
    v.vertex_y = Y_W'(y);
    v.vertex_last = last;
    v.scan_y = Y_W'($urandom);
    return v;
  endfunction

  function automatic spf_req_t make_query(int row);
    spf_req_t v;
    v = '0;
    v.req_type = REQ_QUERY;
    v.vertex_x = X_W'($urandom);
    v.vertex_y = Y_W'($urandom);
    v.vertex_last = 1'($urandom_range(1));
    v.scan_y = Y_W'(row);
    return v;
  endfunction

  // one beat on the command side; start stays high until the next idle gap
  task automatic send_item(input spf_req_t it);
    while (!quiet_phase && $urandom_range(99) < 24) begin
      start <= 1'b0;
      req_i <= make_query($urandom_range(511));
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (it.req_type == REQ_LOAD) store_vertex(it);
    else predict_spans(it.scan_y);
  endtask

  always @(posedge clk_i) begin
    spf_res_t exp_span;
    if (rst_ni && res_strobe_o) begin
      if (span_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected span beat %p", res_o);
      end else begin
        exp_span = span_q.pop_front();
        if (res_o !== exp_span) begin
          mismatches++;
          if (mismatches <= 10)
            $display("span mismatch: expected %p, got %p", exp_span, res_o);
        end
      end
    end
  end

  task automatic test_empty_polygon();
    send_item(make_query(0));
    send_item(make_query(479));
  endtask

  task automatic test_extremes();
    send_item(make_vertex(0, 0, 0));
    send_item(make_vertex(1023, 0, 0));
    send_item(make_vertex(1023, 511, 0));
    send_item(make_vertex(0, 511, 1));
    send_item(make_query(0));
    send_item(make_query(255));
    send_item(make_query(479));
    send_item(make_query(480));
    send_item(make_query(511));
    // single vertex, then an open triangle with a horizontal edge
    send_item(make_vertex(500, 100, 1));
    send_item(make_query(100));
    send_item(make_vertex(10, 10, 0));
    send_item(make_vertex(900, 10, 0));
    send_item(make_vertex(400, 300, 0));
    send_item(make_query(10));
    send_item(make_query(150));
    send_item(make_query(300));
  endtask

  task automatic test_overflow();
    for (int i = 0; i < 20; i++)
      send_item(make_vertex($urandom_range(1023), (i % 2) ? 50 : 400, i == 19));
    send_item(make_query(200));
    // open polygon with odd vertex count, two of its edges cross the queried row
    send_item(make_vertex(100, 10, 0));
    send_item(make_vertex(700, 300, 0));
    send_item(make_vertex(300, 200, 0));
    send_item(make_query(100));
  endtask

  task automatic test_random();
    int sent, nv;
    sent = 0;
    while (sent < 380) begin
      quiet_phase = (sent > 150 && sent < 200);
      if ($urandom_range(9) == 0) begin
        // noise: stray loads without a close
        send_item(make_vertex($urandom_range(1023), $urandom_range(511), 0));
        sent++;
      end else begin
        nv = ($urandom_range(9) == 0) ? $urandom_range(1, 18) : $urandom_range(3, 8);
        for (int i = 0; i < nv; i++) begin
          send_item(make_vertex($urandom_range(1023), $urandom_range(511), i == nv - 1));
          sent++;
        end
      end
      for (int k = $urandom_range(1, 4); k > 0; k--) begin
        send_item(make_query($urandom_range(9) == 0 ? $urandom_range(480, 511)
                                                     : $urandom_range(479)));
        sent++;
      end
    end
    quiet_phase = 1'b0;
  endtask

  initial begin
    start = 1'b0;
    req_i = '0;
    rst_ni = 1'b0;
    poly_n = 0;
    poly_closed = 1'b1;
    mismatches = 0;
    timed_out = 1'b0;
    cycles = 0;
    quiet_phase = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_polygon();
    test_extremes();
    test_overflow();
    test_random();
    start <= 1'b0;
    while (span_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && span_q.size() == 0)
      $display("** scanline_polygon_span_fill: PASSED **");
    else
      $display("** scanline_polygon_span_fill: FAILED **");
    $finish;
  end

endmodule
